// ===== rtl/s2l_pkg.sv =====
// s2l_pkg: payload types, matrix and white point constants, gamma and cube root table builders
// for the srgb to cielab pixel core; depends on nothing
package s2l_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [7:0] out_third;
    } t_result;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic       CFG_IDX_MODE = 1'b0;
    localparam logic       MODE_XYZ     = 1'b0;
    localparam logic       MODE_LAB     = 1'b1;

    // srgb to xyz, d65, q0.16
    localparam logic [15:0] MTX [3][3] = '{
        '{16'd27031, 16'd23434, 16'd11825},
        '{16'd13938, 16'd46868, 16'd4730},
        '{16'd1267,  16'd7811,  16'd62279}
    };

    // reciprocal of the white point per channel, q16
    localparam logic [16:0] NORM_SCALE [3] = '{17'd68951, 17'd65536, 17'd60189};

    typedef logic [16:0] t_gamma_tab [256];

    function automatic logic [63:0] pow5_q24(input logic [63:0] w);
        logic [63:0] p;
        p = w;
        for (int k = 0; k < 4; k++) begin
            p = (p * w) >> 24;
        end
        return p;
    endfunction

    function automatic logic [63:0] pow3_q24(input logic [63:0] w);
        return (((w * w) >> 24) * w) >> 24;
    endfunction

    function automatic logic [63:0] root_q24(input logic [63:0] target, input logic fifth);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        lo = 64'd0;
        hi = 64'd1 << 24;
        for (int k = 0; k < 26; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                p   = fifth ? pow5_q24(mid) : pow3_q24(mid);
                if (p <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return lo;
    endfunction

    function automatic logic [16:0] gamma_entry(input logic [63:0] v);
        logic [63:0] g;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] w;
        logic [63:0] lin;
        if (v <= 64'd10) begin
            g = (v * 64'd6553600 + 64'd164730) / 64'd329460;
        end else begin
            u   = ((64'd1000 * v + 64'd14025) << 24) / 64'd269025;
            u2  = (u * u) >> 24;
            w   = root_q24(u2, 1'b1);
            lin = (u2 * w) >> 24;
            g   = (lin + 64'd128) >> 8;
        end
        return g[16:0];
    endfunction

    function automatic t_gamma_tab build_gamma();
        t_gamma_tab tab;
        for (int v = 0; v < 256; v++) begin
            tab[v] = gamma_entry(64'(v));
        end
        return tab;
    endfunction

    localparam t_gamma_tab GAMMA_TAB = build_gamma();

    // lab f() curve at i / 2^bits, q16
    function automatic logic [16:0] cube_entry(input logic [63:0] i, input int bits);
        logic [63:0] t24;
        logic [63:0] c;
        logic [63:0] e;
        t24 = i << (24 - bits);
        if (t24 * 64'd1000000 > (64'd8856 << 24)) begin
            c = root_q24(t24, 1'b0);
            e = (c + 64'd128) >> 8;
        end else begin
            e = (64'd9033 * t24 + (64'd160 << 24) + 64'd148480) / 64'd296960;
        end
        return e[16:0];
    endfunction

endpackage

// ===== rtl/s2l_lab_curve.sv =====
// s2l_lab_curve: lab f() curve, cube root table with linear interpolation, two register stages
// depends on s2l_pkg
module s2l_lab_curve
    import s2l_pkg::*;
#(
    parameter int CUBE_ROOT_INDEX_BITS = 10
) (
    input  logic        i_clk,
    input  logic [16:0] i_ratio,
    output logic [16:0] o_f
);

    localparam int SHIFT   = 16 - CUBE_ROOT_INDEX_BITS;
    localparam int ENTRIES = (1 << CUBE_ROOT_INDEX_BITS) + 1;
    localparam int SUM_W   = 17 + SHIFT + 2;

    // each entry holds the pair T[i+1], T[i]; the top entry repeats itself
    typedef logic [33:0] t_pair_tab [ENTRIES];

    function automatic t_pair_tab build_pairs();
        t_pair_tab   tab;
        logic [16:0] lo;
        logic [16:0] hi;
        for (int i = 0; i < ENTRIES; i++) begin
            lo = cube_entry(64'(i), CUBE_ROOT_INDEX_BITS);
            hi = (i == ENTRIES - 1) ? lo : cube_entry(64'(i + 1), CUBE_ROOT_INDEX_BITS);
            tab[i] = {hi, lo};
        end
        return tab;
    endfunction

    localparam t_pair_tab PAIR_TAB = build_pairs();

    logic [33:0]      r_pair;
    logic [SHIFT-1:0] r_frac;
    logic [16:0]      r_f;
    logic [SHIFT:0]   w_wlo;
    logic [SHIFT:0]   w_whi;
    logic [SUM_W-1:0] w_sum;

    always_ff @(posedge i_clk) begin
        r_pair <= PAIR_TAB[i_ratio[16:SHIFT]];
        r_frac <= i_ratio[SHIFT-1:0];
    end

    always_comb begin
        w_whi = {1'b0, r_frac};
        w_wlo = {1'b1, {SHIFT{1'b0}}} - w_whi;
        w_sum = SUM_W'(r_pair[16:0]) * SUM_W'(w_wlo)
              + SUM_W'(r_pair[33:17]) * SUM_W'(w_whi);
    end

    always_ff @(posedge i_clk) begin
        r_f <= w_sum[SHIFT+16:SHIFT];
    end

    assign o_f = r_f;

endmodule

// ===== rtl/srgb_to_cielab_pixel_core.sv =====
// srgb_to_cielab_pixel_core: top level, srgb pixel to cie lab or xyz bytes, seven stage pipeline
// depends on s2l_pkg and s2l_lab_curve
//
// a pixel word is taken on i_pixel at every rising edge with start high and busy low; busy is
// never raised, so one pixel per clock is taken with no gaps. each result word stands on
// o_result for exactly one cycle with o_result_valid high, in the order the pixels came in. the
// pipeline runs gamma table, matrix products, matrix sums, white point scaling, cube root table
// read, interpolation and output stages, each one register deep. the receiver cannot hold
// results off and none is needed. output_mode sits at byte address 0 of the apb port (bit 0:
// 0 gives x y z, 1 gives l a b); writes take effect on pixels taken afterwards. reset is
// synchronous, active low, clears the valid bits in flight and sets output_mode to lab; all
// tables are constant, so pixels are taken from the first cycle after reset.
module srgb_to_cielab_pixel_core
    import s2l_pkg::*;
#(
    parameter int CUBE_ROOT_INDEX_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_pixel      i_pixel,
    output logic        o_result_valid,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int STAGES = 7;

    logic               r_mode;
    logic [STAGES-1:0]  r_vld;
    logic [STAGES-1:0]  r_mode_p;

    logic [7:0]  w_chan   [3];
    logic [16:0] r_lin    [3];
    logic [32:0] r_prod   [3][3];
    logic [33:0] w_sum    [3];
    logic [16:0] r_xyz    [3];
    logic [24:0] w_xb     [3];
    logic [33:0] w_norm   [3];
    logic [16:0] r_ratio  [3];
    logic [7:0]  r_xyzb   [3];
    logic [7:0]  r_xyzb_d1[3];
    logic [7:0]  r_xyzb_d2[3];
    logic [16:0] w_f      [3];
    logic [7:0]  w_lab    [3];
    t_result     r_result;

    logic signed [27:0] w_fx;
    logic signed [27:0] w_fy;
    logic signed [27:0] w_fz;

    function automatic logic [7:0] lab_byte(input logic signed [27:0] v);
        logic [11:0] q;
        q = v[27:16];
        if (v <= 28'sd0) begin
            return 8'd0;
        end else if (q > 12'd255) begin
            return 8'hff;
        end else begin
            return q[7:0];
        end
    endfunction

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LAB;
        end else if (psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    assign busy = 1'b0;

    // valid and mode travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], start && !busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode_p <= {r_mode_p[STAGES-2:0], r_mode};
    end

    assign w_chan[0] = i_pixel.red;
    assign w_chan[1] = i_pixel.green;
    assign w_chan[2] = i_pixel.blue;

    // gamma table and matrix products
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_lin[c] <= GAMMA_TAB[w_chan[c]];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[r][c] <= 33'(r_lin[c]) * 33'(MTX[r][c]);
            end
        end
    end

    // matrix sums, then white point scaling and xyz bytes
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 34'(r_prod[r][0]) + 34'(r_prod[r][1]) + 34'(r_prod[r][2]) + 34'd32768;
            w_xb[r]   = 25'(r_xyz[r]) * 25'd100;
            w_norm[r] = 34'(r_xyz[r]) * 34'(NORM_SCALE[r]) + 34'd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_xyz[r] <= w_sum[r][32:16];
            if (w_norm[r][33:16] > 18'(ONE_Q16)) begin
                r_ratio[r] <= ONE_Q16;
            end else begin
                r_ratio[r] <= w_norm[r][32:16];
            end
            if (w_xb[r][24:16] > 9'd255) begin
                r_xyzb[r] <= 8'hff;
            end else begin
                r_xyzb[r] <= w_xb[r][23:16];
            end
            r_xyzb_d1[r] <= r_xyzb[r];
            r_xyzb_d2[r] <= r_xyzb_d1[r];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_curve
        s2l_lab_curve #(
            .CUBE_ROOT_INDEX_BITS(CUBE_ROOT_INDEX_BITS)
        ) u_curve (
            .i_clk  (i_clk),
            .i_ratio(r_ratio[g]),
            .o_f    (w_f[g])
        );
    end

    // l, a, b and output word
    always_comb begin
        w_fx     = signed'(28'(w_f[0]));
        w_fy     = signed'(28'(w_f[1]));
        w_fz     = signed'(28'(w_f[2]));
        w_lab[0] = lab_byte(w_fy * 28'sd116 - 28'sd1048576);
        w_lab[1] = lab_byte((w_fx - w_fy) * 28'sd500 + 28'sd8388608);
        w_lab[2] = lab_byte((w_fy - w_fz) * 28'sd200 + 28'sd8388608);
    end

    always_ff @(posedge i_clk) begin
        if (r_mode_p[STAGES-2] == MODE_LAB) begin
            r_result <= '{out_first: w_lab[0], out_second: w_lab[1], out_third: w_lab[2]};
        end else begin
            r_result <= '{out_first: r_xyzb_d2[0], out_second: r_xyzb_d2[1],
                          out_third: r_xyzb_d2[2]};
        end
    end

    assign o_result       = r_result;
    assign o_result_valid = r_vld[STAGES-1];

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_result_valid)
        else $error("accepted pixel gave no result after seven cycles");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 7))
        else $error("result word with no matching pixel");

    a_lab_lightness: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_mode_p[STAGES-1] == MODE_LAB) |-> (o_result.out_first <= 8'd100))
        else $error("lightness above 100");

    a_xyz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && r_mode_p[STAGES-1] == MODE_XYZ)
            |-> (o_result.out_first <= 8'd95 && o_result.out_second <= 8'd100
                 && o_result.out_third <= 8'd108))
        else $error("xyz byte beyond the white point range");

endmodule
